FILE: design/pmd_pkg.sv
// shared constants, codes and payload types for the ps/2 mouse packet decoder
`default_nettype none

package pmd_pkg;

  localparam int CNT_W     = 32;  // width of the saturating error counters
  localparam int OUT_CNT_W = 32;  // counter width carried on the result channel
  localparam int POS_W     = 2;
  localparam int BTN_W     = 3;

  // bit positions inside the first packet byte
  localparam int SYNC_BIT  = 3;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;

  // packet byte positions
  localparam logic [POS_W-1:0] POS_FLAGS = 2'd0;
  localparam logic [POS_W-1:0] POS_X     = 2'd1;
  localparam logic [POS_W-1:0] POS_Y     = 2'd2;

  typedef enum logic [2:0] {
    EV_STORED   = 3'd0,
    EV_MOTION   = 3'd1,
    EV_OVERFLOW = 3'd2,
    EV_BADSYNC  = 3'd3,
    EV_IGNORED  = 3'd4
  } ev_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_mouse;
  } in_item_t;

  typedef struct packed {
    ev_t                  event_res;
    logic signed [7:0]    delta_x;
    logic signed [7:0]    delta_y;
    logic [BTN_W-1:0]     buttons;
    logic [OUT_CNT_W-1:0] bad_packet_count;
    logic [OUT_CNT_W-1:0] overflow_count;
  } res_item_t;

endpackage

`default_nettype wire

FILE: design/pmd_stream_if.sv
// valid/ready channel interfaces for the byte input and the result output
`default_nettype none

interface pmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_mouse;

  modport source (output valid, output data_byte, output from_mouse, input ready);
  modport sink (input valid, input data_byte, input from_mouse, output ready);
endinterface

interface pmd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic [2:0]        buttons;
  logic [31:0]       bad_packet_count;
  logic [31:0]       overflow_count;

  modport source (output valid, output event_res, output delta_x, output delta_y,
                  output buttons, output bad_packet_count, output overflow_count,
                  input ready);
  modport sink (input valid, input event_res, input delta_x, input delta_y,
                input buttons, input bad_packet_count, input overflow_count,
                output ready);
endinterface

`default_nettype wire

FILE: design/ps2_mouse_packet_decoder.sv
// top level of the ps/2 mouse 3-byte packet decoder
//
//   channel   direction  contents
//   in_ch     sink       data_byte[7:0], from_mouse
//   out_ch    source     event_res, delta_x, delta_y, buttons, two 32-bit counters
//   cfg_*     input      reporting_enabled, written when cfg_wr_en is high
//
// one byte per cycle sustained while the result sink is ready; each accepted byte goes
// through the input register, decode and the result register before its result is offered
// synchronous active-low reset clears position, counters and reporting_enabled
// a stalled result holds; the input register keeps taking bytes until both stages are full
`default_nettype none

module ps2_mouse_packet_decoder
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pmd_in_if.sink    in_ch,
  pmd_out_if.source out_ch,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  logic      item_valid;
  in_item_t  item;
  logic      room;
  logic      fire;
  res_item_t res;

  assign fire = item_valid && room;

  pmd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  pmd_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .fire        (fire),
    .res         (res)
  );

  pmd_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: design/pmd_in_stage.sv
// input register: captures one byte transaction and holds it until decoded
`default_nettype none

module pmd_in_stage
  import pmd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pmd_in_if.sink    in_ch,
  input  wire logic take,
  output logic      item_valid,
  output in_item_t  item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // a held item leaving this cycle frees the slot for a new one
  assign in_ch.ready = !valid_r || take;
  assign valid_nxt   = (in_ch.valid && in_ch.ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte  <= in_ch.data_byte;
      item_r.from_mouse <= in_ch.from_mouse;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

FILE: design/pmd_decode.sv
// packet assembly state, sync and overflow checks, saturating counters
`default_nettype none

module pmd_decode
  import pmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data,
  input  wire in_item_t  item,
  input  wire logic      fire,
  output res_item_t      res
);

  logic              rpt_en_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [CNT_W-1:0]  bad_r, bad_nxt;
  logic [CNT_W-1:0]  ovf_r, ovf_nxt;
  ev_t               ev;
  logic [7:0]        dx, dy;
  logic [BTN_W-1:0]  btn;

  always_comb begin
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    x_nxt     = x_r;
    bad_nxt   = bad_r;
    ovf_nxt   = ovf_r;
    ev        = EV_IGNORED;
    dx        = 8'd0;
    dy        = 8'd0;
    btn       = '0;
    if (item.from_mouse && rpt_en_r) begin
      case (pos_r)
        POS_X: begin
          x_nxt   = item.data_byte;
          pos_nxt = POS_Y;
          ev      = EV_STORED;
        end
        POS_Y: begin
          pos_nxt = POS_FLAGS;
          if (!flags_r[SYNC_BIT]) begin
            bad_nxt = (bad_r == '1) ? bad_r : bad_r + 1'b1;
            ev      = EV_BADSYNC;
          end else if (flags_r[X_OVF_BIT] || flags_r[Y_OVF_BIT]) begin
            ovf_nxt = (ovf_r == '1) ? ovf_r : ovf_r + 1'b1;
            ev      = EV_OVERFLOW;
          end else begin
            dx  = x_r;
            dy  = item.data_byte;
            btn = flags_r[BTN_W-1:0];
            ev  = EV_MOTION;
          end
        end
        default: begin
          // first byte, or a position that never occurs
          if (!item.data_byte[SYNC_BIT]) begin
            bad_nxt = (bad_r == '1) ? bad_r : bad_r + 1'b1;
            pos_nxt = POS_FLAGS;
            ev      = EV_BADSYNC;
          end else begin
            flags_nxt = item.data_byte;
            pos_nxt   = POS_X;
            ev        = EV_STORED;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.event_res        = ev;
    res.delta_x          = dx;
    res.delta_y          = dy;
    res.buttons          = btn;
    res.bad_packet_count = OUT_CNT_W'(bad_nxt);
    res.overflow_count   = OUT_CNT_W'(ovf_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_en_r <= 1'b0;
      pos_r    <= POS_FLAGS;
      bad_r    <= '0;
      ovf_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        rpt_en_r <= cfg_wr_data;
      end
      if (fire) begin
        pos_r <= pos_nxt;
        bad_r <= bad_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // packet bytes need no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      flags_r <= flags_nxt;
      x_r     <= x_nxt;
    end
  end

  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("byte position reached an unused code");

  a_motion_on_third: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev == EV_MOTION |-> pos_r == POS_Y)
    else $error("motion reported before a full packet");

  a_first_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pos_r == POS_FLAGS && ev == EV_STORED |=> pos_r == POS_X)
    else $error("accepted first byte did not advance position");

  a_bad_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bad_r >= $past(bad_r))
    else $error("bad packet counter decreased");

  a_ovf_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ovf_r >= $past(ovf_r))
    else $error("overflow counter decreased");

endmodule

`default_nettype wire

FILE: design/pmd_out_stage.sv
// result register: holds one decoded transaction until the sink takes it
`default_nettype none

module pmd_out_stage
  import pmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire res_item_t res,
  output logic           room,
  pmd_out_if.source      out_ch
);

  logic      valid_r;
  res_item_t res_r;

  assign room = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.event_res        = res_r.event_res;
  assign out_ch.delta_x          = res_r.delta_x;
  assign out_ch.delta_y          = res_r.delta_y;
  assign out_ch.buttons          = res_r.buttons;
  assign out_ch.bad_packet_count = res_r.bad_packet_count;
  assign out_ch.overflow_count   = res_r.overflow_count;

endmodule

`default_nettype wire
